// ===== rtl/sos_pkg.sv =====
`timescale 1ns / 1ps

package sos_pkg;

	// Default sizes of the stack array.
	localparam int NUM_SUB_STACKS_DEF = 16;
	localparam int MAX_CAPACITY_DEF = 16;

	// Capacity register.
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd3;

	// Value returned when nothing is popped.
	localparam logic signed [31:0] NO_VALUE = -32'sd1;

	// Operation codes.
	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP = 2'd1;
	localparam logic [1:0] OP_POP_AT = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] value;
		logic [3:0]         stack_index;
	} req_t;

	typedef struct packed {
		logic signed [31:0] value_res;
		logic [1:0]         status;
	} res_t;

	// Microcode fields.
	typedef enum logic [3:0] {
		C_NEXT,
		C_ALWAYS,
		C_DISPATCH,
		C_INUSE_ZERO,
		C_INUSE_FULL,
		C_FILL_ZERO,
		C_FILL_NZ,
		C_FILL_LT_CAP,
		C_IDX_BAD
	} cond_t;

	typedef enum logic [1:0] {
		FA_LAST,
		FA_NEXT,
		FA_IDX
	} fsel_t;

	typedef enum logic [1:0] {
		FW_NONE,
		FW_ZERO,
		FW_INC,
		FW_DEC
	} fwr_t;

	typedef enum logic [1:0] {
		IU_NONE,
		IU_INC,
		IU_DEC,
		IU_DEC_IF_ONE
	} iu_t;

	typedef enum logic [1:0] {
		EM_NONE,
		EM_WRITE,
		EM_READ
	} em_t;

	typedef enum logic [1:0] {
		RS_POPVAL,
		RS_OK,
		RS_EMPTY,
		RS_FULL
	} rsel_t;

	localparam int STEP_W = 5;
	typedef logic [STEP_W-1:0] step_t;

	typedef struct packed {
		cond_t cond;
		step_t target;
		fsel_t fsel;
		fwr_t  fwr;
		iu_t   iu;
		em_t   em;
		rsel_t rsel;
		logic  done;
	} ucw_t;

	// Status flags from the datapath to the sequencer.
	typedef struct packed {
		logic [1:0] op;
		logic       inuse_zero;
		logic       inuse_full;
		logic       fill_zero;
		logic       fill_lt_cap;
		logic       idx_bad;
	} flg_t;

	// Program addresses.
	localparam step_t S_DISP   = 5'd0;
	localparam step_t S_P0     = 5'd1;
	localparam step_t S_P1     = 5'd2;
	localparam step_t S_P2     = 5'd3;
	localparam step_t S_POPEN  = 5'd4;
	localparam step_t S_PWAIT  = 5'd5;
	localparam step_t S_PSTORE = 5'd6;
	localparam step_t S_Q0     = 5'd7;
	localparam step_t S_Q1     = 5'd8;
	localparam step_t S_Q2     = 5'd9;
	localparam step_t S_Q3     = 5'd10;
	localparam step_t S_QTAKE  = 5'd11;
	localparam step_t S_QRES   = 5'd12;
	localparam step_t S_A0     = 5'd13;
	localparam step_t S_A1     = 5'd14;
	localparam step_t S_A2     = 5'd15;
	localparam step_t S_REMPTY = 5'd16;
	localparam step_t S_RFULL  = 5'd17;

	function automatic ucw_t mk(cond_t c, step_t t, fsel_t f, fwr_t w, iu_t i, em_t e,
			rsel_t r, logic d);
		ucw_t u;
		u.cond = c;
		u.target = t;
		u.fsel = f;
		u.fwr = w;
		u.iu = i;
		u.em = e;
		u.rsel = r;
		u.done = d;
		return u;
	endfunction

	// The control store. A fill count read issued in one step is seen in the next.
	function automatic ucw_t ucode(step_t s);
		ucw_t u;
		unique case (s)
			S_DISP:   u = mk(C_DISPATCH, S_DISP, FA_LAST, FW_NONE, IU_NONE, EM_NONE,
					RS_EMPTY, 1'b0);
			S_P0:     u = mk(C_INUSE_ZERO, S_POPEN, FA_LAST, FW_NONE, IU_NONE, EM_NONE,
					RS_EMPTY, 1'b0);
			S_P1:     u = mk(C_FILL_LT_CAP, S_PSTORE, FA_LAST, FW_NONE, IU_NONE, EM_NONE,
					RS_EMPTY, 1'b0);
			S_P2:     u = mk(C_INUSE_FULL, S_RFULL, FA_LAST, FW_NONE, IU_NONE, EM_NONE,
					RS_EMPTY, 1'b0);
			S_POPEN:  u = mk(C_NEXT, S_DISP, FA_NEXT, FW_ZERO, IU_INC, EM_NONE,
					RS_EMPTY, 1'b0);
			S_PWAIT:  u = mk(C_NEXT, S_DISP, FA_LAST, FW_NONE, IU_NONE, EM_NONE,
					RS_EMPTY, 1'b0);
			S_PSTORE: u = mk(C_NEXT, S_DISP, FA_LAST, FW_INC, IU_NONE, EM_WRITE,
					RS_OK, 1'b1);
			S_Q0:     u = mk(C_INUSE_ZERO, S_REMPTY, FA_LAST, FW_NONE, IU_NONE, EM_NONE,
					RS_EMPTY, 1'b0);
			S_Q1:     u = mk(C_FILL_NZ, S_QTAKE, FA_LAST, FW_NONE, IU_NONE, EM_NONE,
					RS_EMPTY, 1'b0);
			S_Q2:     u = mk(C_NEXT, S_DISP, FA_LAST, FW_NONE, IU_DEC, EM_NONE,
					RS_EMPTY, 1'b0);
			S_Q3:     u = mk(C_ALWAYS, S_Q0, FA_LAST, FW_NONE, IU_NONE, EM_NONE,
					RS_EMPTY, 1'b0);
			S_QTAKE:  u = mk(C_NEXT, S_DISP, FA_LAST, FW_DEC, IU_DEC_IF_ONE, EM_READ,
					RS_EMPTY, 1'b0);
			S_QRES:   u = mk(C_NEXT, S_DISP, FA_LAST, FW_NONE, IU_NONE, EM_NONE,
					RS_POPVAL, 1'b1);
			S_A0:     u = mk(C_IDX_BAD, S_REMPTY, FA_IDX, FW_NONE, IU_NONE, EM_NONE,
					RS_EMPTY, 1'b0);
			S_A1:     u = mk(C_FILL_ZERO, S_REMPTY, FA_IDX, FW_NONE, IU_NONE, EM_NONE,
					RS_EMPTY, 1'b0);
			S_A2:     u = mk(C_ALWAYS, S_QRES, FA_IDX, FW_DEC, IU_NONE, EM_READ,
					RS_EMPTY, 1'b0);
			S_RFULL:  u = mk(C_NEXT, S_DISP, FA_LAST, FW_NONE, IU_NONE, EM_NONE,
					RS_FULL, 1'b1);
			default:  u = mk(C_NEXT, S_DISP, FA_LAST, FW_NONE, IU_NONE, EM_NONE,
					RS_EMPTY, 1'b1);
		endcase
		return u;
	endfunction

	// Entry point of each operation's routine.
	function automatic step_t dispatch(logic [1:0] op);
		step_t s;
		unique case (op)
			OP_PUSH:   s = S_P0;
			OP_POP:    s = S_Q0;
			OP_POP_AT: s = S_A0;
			default:   s = S_REMPTY;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/sos_seq.sv =====
`timescale 1ns / 1ps

module sos_seq (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         hold,
	input  sos_pkg::flg_t flg,
	output sos_pkg::ucw_t cw,
	output logic         step_en,
	output logic         busy
);
	import sos_pkg::*;

	step_t step_q;
	step_t step_next;
	logic  busy_q;
	logic  take;

	assign cw = ucode(step_q);
	assign busy = busy_q;

	// A finishing step waits while the result register is still occupied.
	assign step_en = busy_q && !(cw.done && hold);

	always_comb begin
		unique case (cw.cond) inside
			C_NEXT:              take = 1'b0;
			C_ALWAYS, C_DISPATCH: take = 1'b1;
			C_INUSE_ZERO:        take = flg.inuse_zero;
			C_INUSE_FULL:        take = flg.inuse_full;
			C_FILL_ZERO:         take = flg.fill_zero;
			C_FILL_NZ:           take = !flg.fill_zero;
			C_FILL_LT_CAP:       take = flg.fill_lt_cap;
			C_IDX_BAD:           take = flg.idx_bad;
			default:             take = 1'b0;
		endcase
		if (cw.cond == C_DISPATCH) begin
			step_next = dispatch(flg.op);
		end else if (take) begin
			step_next = cw.target;
		end else begin
			step_next = step_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= S_DISP;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= S_DISP;
		end else if (step_en) begin
			if (cw.done) begin
				busy_q <= 1'b0;
				step_q <= S_DISP;
			end else begin
				step_q <= step_next;
			end
		end
	end

endmodule

// ===== rtl/sos_dp.sv =====
`timescale 1ns / 1ps

module sos_dp #(
	parameter int NUM_SUB_STACKS = sos_pkg::NUM_SUB_STACKS_DEF,
	parameter int MAX_CAPACITY = sos_pkg::MAX_CAPACITY_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  sos_pkg::req_t              req,
	input  logic                       cfg_wr_en,
	input  logic [sos_pkg::CAP_W-1:0]  cfg_wr_data,
	input  sos_pkg::ucw_t              cw,
	input  logic                       step_en,
	output sos_pkg::flg_t              flg,
	output sos_pkg::res_t              res
);
	import sos_pkg::*;

	localparam int DEPTH = NUM_SUB_STACKS * MAX_CAPACITY;
	localparam int FA_W = NUM_SUB_STACKS > 1 ? $clog2(NUM_SUB_STACKS) : 1;
	localparam int IU_W = $clog2(NUM_SUB_STACKS + 1);
	localparam int FC_W = $clog2(MAX_CAPACITY + 1);
	localparam int EA_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int CC_W = FC_W > CAP_W ? FC_W : CAP_W;
	localparam int CI_W = IU_W > 4 ? IU_W : 4;

	// Latched request.
	logic [1:0]         op_q;
	logic signed [31:0] value_q;
	logic [3:0]         idx_q;

	logic [CAP_W-1:0] cap_q;
	logic [CC_W-1:0]  cap_eff;
	logic [IU_W-1:0]  in_use_q;

	// Fill counts: a small memory with one valid bit per entry.
	logic [FC_W-1:0] fill_mem [NUM_SUB_STACKS];
	logic [NUM_SUB_STACKS-1:0] fvld_q;
	logic [FC_W-1:0] fill_rd_q;
	logic            fvld_rd_q;
	logic [FA_W-1:0] faddr;
	logic [FC_W-1:0] fd;
	logic [FC_W-1:0] fwdata;
	logic            fill_we;

	// Element store.
	logic signed [31:0] elem_mem [DEPTH];
	logic signed [31:0] elem_rd_q;
	logic [FC_W-1:0]    eoff;
	logic [EA_W-1:0]    eaddr;

	always_ff @(posedge clk) begin
		if (start) begin
			op_q <= req.operation;
			value_q <= req.value;
			idx_q <= req.stack_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// Zero counts as one; anything above a sub-stack's depth saturates.
	always_comb begin
		cap_eff = CC_W'(cap_q);
		if (cap_q == '0) begin
			cap_eff = CC_W'(1);
		end
		if (cap_eff > CC_W'(MAX_CAPACITY)) begin
			cap_eff = CC_W'(MAX_CAPACITY);
		end
	end

	always_comb begin
		unique case (cw.fsel)
			FA_LAST: faddr = FA_W'(in_use_q - 1'b1);
			FA_NEXT: faddr = FA_W'(in_use_q);
			FA_IDX:  faddr = FA_W'(idx_q);
			default: faddr = FA_W'(in_use_q - 1'b1);
		endcase
	end

	assign fd = fvld_rd_q ? fill_rd_q : '0;

	always_comb begin
		unique case (cw.fwr)
			FW_ZERO: fwdata = '0;
			FW_INC:  fwdata = fd + 1'b1;
			FW_DEC:  fwdata = fd - 1'b1;
			default: fwdata = fd;
		endcase
	end

	assign fill_we = step_en && (cw.fwr != FW_NONE);

	always_ff @(posedge clk) begin
		if (fill_we) begin
			fill_mem[faddr] <= fwdata;
		end
		fill_rd_q <= fill_mem[faddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fvld_q <= '0;
			fvld_rd_q <= 1'b0;
		end else begin
			if (fill_we) begin
				fvld_q[faddr] <= 1'b1;
			end
			fvld_rd_q <= fvld_q[faddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
		end else if (step_en) begin
			case (cw.iu)
				IU_INC: in_use_q <= in_use_q + 1'b1;
				IU_DEC: in_use_q <= in_use_q - 1'b1;
				IU_DEC_IF_ONE: begin
					if (fd == FC_W'(1)) begin
						in_use_q <= in_use_q - 1'b1;
					end
				end
				default: in_use_q <= in_use_q;
			endcase
		end
	end

	// A push writes at the current count, a pop reads one below it.
	assign eoff = (cw.em == EM_WRITE) ? fd : fd - 1'b1;
	assign eaddr = EA_W'(faddr) * EA_W'(MAX_CAPACITY) + EA_W'(eoff);

	always_ff @(posedge clk) begin
		if (step_en && cw.em == EM_WRITE) begin
			elem_mem[eaddr] <= value_q;
		end
		if (cw.em == EM_READ) begin
			elem_rd_q <= elem_mem[eaddr];
		end
	end

	always_comb begin
		flg.op = op_q;
		flg.inuse_zero = (in_use_q == '0);
		flg.inuse_full = (in_use_q == IU_W'(NUM_SUB_STACKS));
		flg.fill_zero = (fd == '0);
		flg.fill_lt_cap = (CC_W'(fd) < cap_eff);
		flg.idx_bad = (CI_W'(idx_q) >= CI_W'(in_use_q)) ||
			(CI_W'(idx_q) >= CI_W'(NUM_SUB_STACKS));
	end

	always_comb begin
		unique case (cw.rsel)
			RS_POPVAL: begin
				res.value_res = elem_rd_q;
				res.status = ST_OK;
			end
			RS_OK: begin
				res.value_res = NO_VALUE;
				res.status = ST_OK;
			end
			RS_FULL: begin
				res.value_res = NO_VALUE;
				res.status = ST_FULL;
			end
			default: begin
				res.value_res = NO_VALUE;
				res.status = ST_EMPTY;
			end
		endcase
	end

endmodule

// ===== rtl/set_of_stacks_with_pop_at.sv =====
`timescale 1ns / 1ps

// Set of stacks with pop-at: one logical stack spread over sub-stacks of a
// programmable capacity. Each request (push, pop, or pop from a named
// sub-stack) produces exactly one result on the result channel, carrying the
// popped value or -1, and a status of ok, empty or full.
// Both channels use valid/ready. A request is taken only while the engine is
// idle; the result sits in an output register, so the next request is taken
// while an earlier result still waits for the receiver.
// A push takes longer when it opens a new sub-stack, and a pop, also one that
// finds nothing, takes longer for each empty trailing sub-stack it closes.
// The next request can be taken in the cycle after the result is loaded. The
// run lengths are set by the microprogram, one control word per cycle while
// the final step is not held, and the registered read of the fill-count and
// element memories.
// Reset empties every sub-stack and sets the capacity to 3; the capacity
// register may be written whenever the engine is idle.
// When the receiver stalls, the engine finishes its request and then waits at
// its final step until the result register is free.

module set_of_stacks_with_pop_at #(
	parameter int NUM_SUB_STACKS = sos_pkg::NUM_SUB_STACKS_DEF,
	parameter int MAX_CAPACITY = sos_pkg::MAX_CAPACITY_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  sos_pkg::req_t             req_data,
	output logic                      res_valid,
	input  logic                      res_ready,
	output sos_pkg::res_t             res_data,
	input  logic                      cfg_wr_en,
	input  logic [sos_pkg::CAP_W-1:0] cfg_wr_data
);
	import sos_pkg::*;

	ucw_t cw;
	flg_t flg;
	res_t res_next;
	res_t res_q;
	logic res_valid_q;
	logic step_en;
	logic busy;
	logic start;
	logic hold;
	logic load;

	// Requests are taken only between microprogram runs.
	assign req_ready = !busy;
	assign start = req_valid && !busy;

	// The last step of a run stalls while an untaken result is still held.
	assign hold = res_valid_q && !res_ready;
	assign load = step_en && cw.done;

	sos_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.hold    (hold),
		.flg     (flg),
		.cw      (cw),
		.step_en (step_en),
		.busy    (busy)
	);

	sos_dp #(
		.NUM_SUB_STACKS (NUM_SUB_STACKS),
		.MAX_CAPACITY   (MAX_CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.req         (req_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cw          (cw),
		.step_en     (step_en),
		.flg         (flg),
		.res         (res_next)
	);

	// Output register: loaded at the final step of a run, freed when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data = res_q;

endmodule

// ===== rtl/sos_chk.sv =====
`timescale 1ns / 1ps

module sos_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          res_valid,
	input logic          res_ready,
	input sos_pkg::res_t res_data
);
	import sos_pkg::*;

	// A stalled result stays and does not change.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed or dropped while stalled");

	// Only a successful pop carries a value; every other result carries -1.
	a_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.status != ST_OK |-> res_data.value_res == NO_VALUE)
		else $error("refused request returned a value");

	// In the cycle after a request is taken the engine is busy.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while engine busy");

	// No result can be loaded in the cycle right after a request is taken.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(res_valid))
		else $error("result appeared too early");

endmodule

bind set_of_stacks_with_pop_at sos_chk u_sos_chk (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import sos_pkg::*;

	localparam int NSUB = NUM_SUB_STACKS_DEF;
	localparam int MAXC = MAX_CAPACITY_DEF;

	// The one operation code the block does not define; it must answer empty.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_ready;
	req_t       req_data;
	logic       res_valid;
	logic       res_ready;
	res_t       res_data;
	logic       cfg_wr_en;
	logic [CAP_W-1:0] cfg_wr_data;

	set_of_stacks_with_pop_at DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_data   (req_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Our own picture of the stack array. Words are only read after they were
	// written, so the word store needs no reset.
	logic signed [31:0] held_word [NSUB][MAXC];
	int unsigned        fill_of [NSUB];
	int unsigned        open_stacks;
	logic [CAP_W-1:0]   cap_setting;

	// Results still owed by the block, oldest first.
	res_t pending_results [$];
	int   mismatch_count = 0;

	// Longest idle gap per item for each side; changed from phase to phase so
	// that some phases run with no idling at all.
	int unsigned req_gap_max = 7;
	int unsigned res_gap_max = 7;

	// Applies one request to the local picture and returns what the block must
	// answer. Pushes go to the last open sub-stack or open the next one; pops
	// first close empty trailing sub-stacks; pop-at never rolls over.
	function automatic res_t stack_op_result(req_t r);
		res_t        o;
		int unsigned lim;
		int unsigned s;
		logic        room;
		o.value_res = NO_VALUE;
		o.status = ST_EMPTY;
		case (r.operation)
			OP_PUSH: begin
				// A capacity of zero behaves as one, and anything above the
				// sub-stack depth saturates.
				lim = (cap_setting == 0) ? 1 : int'(cap_setting);
				if (lim > MAXC)
					lim = MAXC;
				room = 1'b1;
				if (open_stacks == 0 || fill_of[open_stacks - 1] >= lim) begin
					if (open_stacks >= NSUB) begin
						room = 1'b0;
					end else begin
						fill_of[open_stacks] = 0;
						open_stacks++;
					end
				end
				if (room && fill_of[open_stacks - 1] < MAXC) begin
					s = open_stacks - 1;
					held_word[s][fill_of[s]] = r.value;
					fill_of[s]++;
					o.status = ST_OK;
				end else begin
					o.status = ST_FULL;
				end
			end
			OP_POP: begin
				while (open_stacks > 0 && fill_of[open_stacks - 1] == 0)
					open_stacks--;
				if (open_stacks > 0) begin
					s = open_stacks - 1;
					fill_of[s]--;
					o.value_res = held_word[s][fill_of[s]];
					if (fill_of[s] == 0)
						open_stacks--;
					o.status = ST_OK;
				end
			end
			OP_POP_AT: begin
				// An emptied sub-stack stays open here, leaving a hole.
				s = r.stack_index;
				if (s < open_stacks && fill_of[s] > 0) begin
					fill_of[s]--;
					o.value_res = held_word[s][fill_of[s]];
					o.status = ST_OK;
				end
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	// Builds a random request. Most pop-at requests name an open sub-stack so
	// that holes actually form; the rest, and the unused code, are noise.
	function automatic req_t random_request(int unsigned push_pct);
		req_t        r;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		r.value = $urandom;
		r.stack_index = 4'($urandom_range(0, 15));
		if (roll < 4)
			r.operation = OP_UNUSED;
		else if (roll < push_pct)
			r.operation = OP_PUSH;
		else if (roll < push_pct + (100 - push_pct) / 2)
			r.operation = OP_POP;
		else
			r.operation = OP_POP_AT;
		if (r.operation == OP_POP_AT && open_stacks > 0 && $urandom_range(0, 4) != 0)
			r.stack_index = 4'($urandom_range(0, open_stacks - 1));
		return r;
	endfunction

	// Presents one request after a random gap and records the expected result
	// at the edge where it is taken. The valid line is only lowered when a gap
	// follows, so back-to-back requests never see it drop and rise in one step.
	// When typed is set, the hand-written answer replaces the predicted one.
	task automatic issue_request(input req_t r, input logic typed, input res_t want);
		int unsigned hold;
		res_t        predicted;
		hold = $urandom_range(0, req_gap_max);
		if (hold != 0) begin
			req_valid <= 1'b0;
			repeat (hold) @(negedge clk);
		end
		req_data <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		predicted = stack_op_result(r);
		pending_results.insert(pending_results.size(), typed ? want : predicted);
		@(negedge clk);
	endtask

	// The capacity is changed only once every result is back, which means the
	// engine has returned to its dispatch step. Values already held stay put.
	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		cfg_wr_data <= cap;
		cfg_wr_en <= 1'b1;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cap_setting = cap;
	endtask

	// Result side: for every result the receiver holds ready low for a random
	// number of cycles, then raises it and keeps it up until a result is taken.
	initial begin : result_sink
		int unsigned hold;
		res_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			hold = $urandom_range(0, res_gap_max);
			if (hold != 0) begin
				res_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!(res_valid && res_ready));
			@(negedge clk);
		end
	end

	// Every result taken is compared with the oldest expectation.
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: value_res %0d status %0d",
					res_data.value_res, res_data.status);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (res_data.value_res !== want.value_res) begin
					$error("value_res: expected %0d, got %0d", want.value_res,
						res_data.value_res);
					mismatch_count++;
				end
				if (res_data.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, res_data.status);
					mismatch_count++;
				end
			end
		end
	end

	// Directed opening run at the reset capacity of three. It covers the empty
	// answers, the unused code, the value extremes, opening a second sub-stack,
	// pop-at outside the open range, a pop-at that empties the last sub-stack
	// while leaving it open, a push that refills it, and a pop that must skip
	// an empty trailing sub-stack before it finds a value.
	typedef struct packed {
		req_t req;
		logic typed;
		res_t want;
	} dir_row_t;

	localparam int DIR_ROWS = 23;
	localparam res_t R_OK = '{NO_VALUE, ST_OK};
	localparam res_t R_EMPTY = '{NO_VALUE, ST_EMPTY};

	dir_row_t opening_rows [DIR_ROWS] = '{
		'{'{OP_POP,    32'sd0,           4'd0},  1'b1, R_EMPTY},
		'{'{OP_POP_AT, 32'sd0,           4'd0},  1'b1, R_EMPTY},
		'{'{OP_UNUSED, 32'sh5555_AAAA,   4'd15}, 1'b1, R_EMPTY},
		'{'{OP_PUSH,   32'sh7FFF_FFFF,   4'd15}, 1'b1, R_OK},
		'{'{OP_PUSH,   32'sh8000_0000,   4'd0},  1'b1, R_OK},
		'{'{OP_PUSH,   32'sd0,           4'd10}, 1'b1, R_OK},
		'{'{OP_PUSH,   -32'sd1,          4'd5},  1'b1, R_OK},
		'{'{OP_POP_AT, 32'sd0,           4'd15}, 1'b1, R_EMPTY},
		'{'{OP_POP_AT, 32'sh7FFF_FFFF,   4'd0},  1'b0, R_EMPTY},
		'{'{OP_POP_AT, 32'sd0,           4'd1},  1'b0, R_EMPTY},
		'{'{OP_POP_AT, 32'sd0,           4'd1},  1'b0, R_EMPTY},
		'{'{OP_PUSH,   32'sh5A5A_5A5A,   4'd9},  1'b0, R_EMPTY},
		'{'{OP_POP,    32'sd0,           4'd0},  1'b0, R_EMPTY},
		'{'{OP_POP_AT, 32'sd0,           4'd1},  1'b0, R_EMPTY},
		'{'{OP_POP,    -32'sd1,          4'd15}, 1'b0, R_EMPTY},
		'{'{OP_POP,    32'sd0,           4'd0},  1'b0, R_EMPTY},
		'{'{OP_POP,    32'sd0,           4'd0},  1'b1, R_EMPTY},
		'{'{OP_PUSH,   32'sd1,           4'd0},  1'b0, R_EMPTY},
		'{'{OP_PUSH,   32'sd2,           4'd0},  1'b0, R_EMPTY},
		'{'{OP_PUSH,   32'sd3,           4'd0},  1'b0, R_EMPTY},
		'{'{OP_PUSH,   32'sd4,           4'd0},  1'b0, R_EMPTY},
		'{'{OP_POP_AT, 32'sd0,           4'd1},  1'b0, R_EMPTY},
		'{'{OP_POP,    32'sd0,           4'd0},  1'b0, R_EMPTY}
	};

	// Random phases. Each one sets a capacity, among them zero, one, the full
	// depth and values above it, and a push share. The deep phase at full depth
	// fills every sub-stack so that pushes get refused; the phase after it
	// lowers the capacity while the stack is still loaded and partly drains it.
	localparam int PHASES = 8;
	int unsigned phase_cap [PHASES]   = '{1, 0, 16, 2, 31, 17, 7, 4};
	int unsigned phase_items [PHASES] = '{120, 100, 380, 160, 100, 120, 110, 110};
	int unsigned phase_push [PHASES]  = '{75, 60, 88, 25, 55, 60, 50, 45};

	initial begin : stimulus
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = CAP_RESET;
		foreach (fill_of[i])
			fill_of[i] = 0;
		open_stacks = 0;
		cap_setting = CAP_RESET;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			issue_request(opening_rows[i].req, opening_rows[i].typed, opening_rows[i].want);

		for (int p = 0; p < PHASES; p++) begin
			write_capacity(CAP_W'(phase_cap[p]));
			req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
			res_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
			for (int n = 0; n < phase_items[p]; n++)
				issue_request(random_request(phase_push[p]), 1'b0, R_EMPTY);
		end

		// Drain, then give the block time to show any stray result.
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Hard stop in case a handshake never completes. Even with every request
	// at its slowest and every gap at its longest, a legal run stays under
	// about a millisecond of simulated time.
	initial begin : watchdog
		#5ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
